/* rtl/abdiou_pkg.sv */
// abdiou_pkg: shared types and constants for the anchor box decode / iou block
// item structs, divider request and response, sequencer states, reciprocal table
// no dependencies
package abdiou_pkg;

  // input item as taken on the input channel
  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_h;
    logic signed [15:0] delta_w;
    logic [15:0]        anchor_cx;
    logic [15:0]        anchor_cy;
    logic [15:0]        anchor_h;
    logic [15:0]        anchor_w;
    logic               last_anchor;
  } in_item_t;

  // result item as driven on the output channel
  typedef struct packed {
    logic [15:0] box_xmin;
    logic [15:0] box_ymin;
    logic [15:0] box_xmax;
    logic [15:0] box_ymax;
    logic [15:0] overlap_ratio;
    logic [13:0] best_anchor;
    logic [15:0] best_ratio;
    logic        pass_done;
  } out_item_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_XMIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_YMIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_XMAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_YMAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNION_BIAS   = 3'd6;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_ANCHORS_DEF = 16384;

  // exp series length and index of the last squaring
  localparam logic [3:0] EXP_TERMS = 4'd10;
  localparam logic [1:0] SQ_LAST   = 2'd3;

  // iou quotient width and divider step count
  localparam int QUOT_W = 16;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [31:0]        inter;
    logic signed [35:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CX,
    S_CY,
    S_EXP_INIT,
    S_EXP_A,
    S_EXP_B,
    S_EXP_C,
    S_SQ_A,
    S_SQ_B,
    S_SIZE_A,
    S_SIZE_B,
    S_CORNER,
    S_INTER,
    S_MUL_I,
    S_MUL_P,
    S_MUL_T,
    S_DEN,
    S_DIV,
    S_DONE
  } state_t;

  // ceil(2^29 / n): floor(m * r >> 29) equals floor(m / n) for m below 2^25
  function automatic logic [29:0] recip(input logic [3:0] n);
    logic [29:0] r;
    case (n)
      4'd1:    r = 30'd536870912;
      4'd2:    r = 30'd268435456;
      4'd3:    r = 30'd178956971;
      4'd4:    r = 30'd134217728;
      4'd5:    r = 30'd107374183;
      4'd6:    r = 30'd89478486;
      4'd7:    r = 30'd76695845;
      4'd8:    r = 30'd67108864;
      4'd9:    r = 30'd59652324;
      4'd10:   r = 30'd53687092;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/anchor_box_decode_iou_argmax.sv */
// anchor box decode with iou against a truth box and running arg-max per pass
// the result is registered when S_DONE finds the output free; the next input
// can be taken in the cycle after that
// the sequence runs on one shared 37x31 multiplier walking two exp series
// (10 terms, then 4 squarings) and the 16-step iou divider
// reset (rst_n, synchronous): config and control registers to defaults, pass tracking cleared
module anchor_box_decode_iou_argmax #(
  parameter int MAX_ANCHORS = abdiou_pkg::MAX_ANCHORS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  abdiou_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output abdiou_pkg::out_item_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [abdiou_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abdiou_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import abdiou_pkg::*;

  // clamp a signed coordinate into [0, lim]
  function automatic logic [15:0] clamp_lim(input logic signed [29:0] v,
                                            input logic [15:0] lim);
    logic [15:0] r;
    if (v < 30'sd0) begin
      r = 16'd0;
    end else if (v > $signed({14'd0, lim})) begin
      r = lim;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  // configuration
  logic [11:0] img_w_r, img_h_r;
  logic [15:0] gx0_r, gy0_r, gx1_r, gy1_r;
  logic [7:0]  bias_r;

  // pass tracking
  logic [13:0] count_r;
  logic [13:0] best_idx_r;
  logic [15:0] best_val_r;
  logic        seen_r;

  // datapath
  in_item_t           item_r;
  logic signed [67:0] prod_r;
  logic signed [36:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [21:0] cx_r, cy_r;
  logic signed [25:0] term_r;
  logic signed [26:0] sum_r;
  logic [3:0]         n_r;
  logic [1:0]         sq_r;
  logic               sgn_r;
  logic               which_r;
  logic [35:0]        s_r;
  logic [27:0]        ph_r, pw_r;
  logic [15:0]        x0_r, y0_r, x1_r, y1_r;
  logic [15:0]        iw_r, ih_r;
  logic [31:0]        inter_r, parea_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // combinational helpers
  logic signed [33:0] ctr_sum;
  logic signed [21:0] ctr_off;
  logic signed [15:0] dsel;
  logic [15:0]        asel;
  logic signed [48:0] px;
  logic [48:0]        px_mag;
  logic [24:0]        q_mag;
  logic signed [25:0] term_nxt;
  logic signed [26:0] sum_nxt;
  logic [60:0]        sq_rnd;
  logic [52:0]        sz_rnd;
  logic [15:0]        xlim, ylim;
  logic [26:0]        hw, hh;
  logic signed [29:0] cx_w, cy_w;
  logic signed [16:0] iw_d, ih_d;
  logic signed [16:0] gdx, gdy;
  logic [15:0]        ix_lo, ix_hi, iy_lo, iy_hi;
  logic signed [35:0] denom;
  logic               out_free;
  logic               take;
  logic [14:0]        count_inc;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  abdiou_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 12'd416;
      img_h_r <= 12'd416;
      gx0_r   <= '0;
      gy0_r   <= '0;
      gx1_r   <= '0;
      gy1_r   <= '0;
      bias_r  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[11:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[11:0];
        CFG_TRUTH_XMIN:   gx0_r   <= cfg_wdata;
        CFG_TRUTH_YMIN:   gy0_r   <= cfg_wdata;
        CFG_TRUTH_XMAX:   gx1_r   <= cfg_wdata;
        CFG_TRUTH_YMAX:   gy1_r   <= cfg_wdata;
        CFG_UNION_BIAS:   bias_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // shared helpers
  assign out_free  = !out_valid_r || !out_stall;
  assign dsel      = which_r ? item_r.delta_w : item_r.delta_h;
  assign asel      = which_r ? item_r.anchor_w : item_r.anchor_h;

  // center offset: floor((size*delta + 2048) / 4096)
  assign ctr_sum   = $signed(prod_r[33:0]) + 34'sd2048;
  assign ctr_off   = ctr_sum[33:12];

  // series term: |term*x| >> 24, then divided by n through the reciprocal
  assign px        = $signed(prod_r[48:0]);
  assign px_mag    = px[48] ? 49'(-px) : 49'(px);
  assign q_mag     = prod_r[53:29];
  assign term_nxt  = sgn_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign sum_nxt   = sum_r + {term_nxt[25], term_nxt};

  // rounded q.24 products
  assign sq_rnd    = prod_r[60:0] + 61'd8388608;
  assign sz_rnd    = prod_r[52:0] + 53'd8388608;

  // clamp limits and corners
  assign xlim      = (img_w_r == 12'd0) ? 16'd0 : {img_w_r - 12'd1, 4'd0};
  assign ylim      = (img_h_r == 12'd0) ? 16'd0 : {img_h_r - 12'd1, 4'd0};
  assign hw        = pw_r[27:1];
  assign hh        = ph_r[27:1];
  assign cx_w      = {{8{cx_r[21]}}, cx_r};
  assign cy_w      = {{8{cy_r[21]}}, cy_r};

  // intersection edges
  assign ix_lo     = (x0_r > gx0_r) ? x0_r : gx0_r;
  assign ix_hi     = (x1_r < gx1_r) ? x1_r : gx1_r;
  assign iy_lo     = (y0_r > gy0_r) ? y0_r : gy0_r;
  assign iy_hi     = (y1_r < gy1_r) ? y1_r : gy1_r;
  assign iw_d      = $signed({1'b0, ix_hi}) - $signed({1'b0, ix_lo});
  assign ih_d      = $signed({1'b0, iy_hi}) - $signed({1'b0, iy_lo});
  assign gdx       = $signed({1'b0, gx1_r}) - $signed({1'b0, gx0_r});
  assign gdy       = $signed({1'b0, gy1_r}) - $signed({1'b0, gy0_r});

  // union plus bias, truth area taken from the multiplier
  assign denom     = $signed({4'd0, parea_r}) + $signed(prod_r[35:0])
                   - $signed({4'd0, inter_r}) + $signed({28'd0, bias_r});

  // arg-max decision
  assign take      = !seen_r || (div_rsp.quot > best_val_r);
  assign count_inc = {1'b0, count_r} + 15'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_CX;
      S_CX:       state_nxt = S_CY;
      S_CY:       state_nxt = S_EXP_INIT;
      S_EXP_INIT: state_nxt = S_EXP_A;
      S_EXP_A:    state_nxt = S_EXP_B;
      S_EXP_B:    state_nxt = S_EXP_C;
      S_EXP_C:    state_nxt = (n_r == EXP_TERMS) ? S_SQ_A : S_EXP_A;
      S_SQ_A:     state_nxt = S_SQ_B;
      S_SQ_B:     state_nxt = (sq_r == SQ_LAST) ? S_SIZE_A : S_SQ_A;
      S_SIZE_A:   state_nxt = S_SIZE_B;
      S_SIZE_B:   state_nxt = which_r ? S_CORNER : S_EXP_INIT;
      S_CORNER:   state_nxt = S_INTER;
      S_INTER:    state_nxt = S_MUL_I;
      S_MUL_I:    state_nxt = S_MUL_P;
      S_MUL_P:    state_nxt = S_MUL_T;
      S_MUL_T:    state_nxt = S_DEN;
      S_DEN:      state_nxt = S_DIV;
      S_DIV:      if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider start, input stall
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.inter = inter_r;
    div_req.denom = denom;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CX: begin
        mul_a = {21'd0, item_r.anchor_w};
        mul_b = {{15{item_r.delta_x[15]}}, item_r.delta_x};
      end
      S_CY: begin
        mul_a = {21'd0, item_r.anchor_h};
        mul_b = {{15{item_r.delta_y[15]}}, item_r.delta_y};
      end
      S_EXP_A: begin
        mul_a = {{11{term_r[25]}}, term_r};
        mul_b = {{7{dsel[15]}}, dsel, 8'd0};
      end
      S_EXP_B: begin
        mul_a = {12'd0, px_mag[48:24]};
        mul_b = {1'b0, recip(n_r)};
      end
      S_SQ_A: begin
        mul_a = {7'd0, s_r[29:0]};
        mul_b = {1'b0, s_r[29:0]};
      end
      S_SIZE_A: begin
        mul_a = {1'b0, s_r};
        mul_b = {15'd0, asel};
      end
      S_MUL_I: begin
        mul_a = {21'd0, iw_r};
        mul_b = {15'd0, ih_r};
      end
      S_MUL_P: begin
        mul_a = {21'd0, x1_r - x0_r};
        mul_b = {15'd0, y1_r - y0_r};
      end
      S_MUL_T: begin
        mul_a = {{20{gdx[16]}}, gdx};
        mul_b = {{14{gdy[16]}}, gdy};
      end
      S_DEN: begin
        div_req.start = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      best_idx_r  <= '0;
      best_val_r  <= '0;
      seen_r      <= 1'b0;
      n_r         <= 4'd1;
      sq_r        <= '0;
      which_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CY:       which_r <= 1'b0;
        S_EXP_INIT: n_r <= 4'd1;
        S_EXP_C: begin
          n_r  <= n_r + 4'd1;
          sq_r <= '0;
        end
        S_SQ_B:     sq_r <= sq_r + 2'd1;
        S_SIZE_B:   which_r <= 1'b1;
        S_DONE: begin
          if (out_free) begin
            if (item_r.last_anchor) begin
              count_r    <= '0;
              best_idx_r <= '0;
              best_val_r <= '0;
              seen_r     <= 1'b0;
            end else begin
              if (take) begin
                best_idx_r <= count_r;
                best_val_r <= div_rsp.quot;
                seen_r     <= 1'b1;
              end
              if (32'(count_inc) >= 32'(MAX_ANCHORS)) begin
                count_r <= '0;
              end else begin
                count_r <= count_inc[13:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE:   if (in_valid) item_r <= in_data;
      S_CY:     cx_r <= $signed({6'd0, item_r.anchor_cx}) + ctr_off;
      S_EXP_INIT: begin
        if (!which_r) begin
          cy_r <= $signed({6'd0, item_r.anchor_cy}) + ctr_off;
        end
        term_r <= 26'sd16777216;
        sum_r  <= 27'sd16777216;
      end
      S_EXP_B:  sgn_r <= px[48];
      S_EXP_C: begin
        term_r <= term_nxt;
        sum_r  <= sum_nxt;
        s_r    <= (sum_nxt > 27'sd0) ? {10'd0, sum_nxt[25:0]} : 36'd0;
      end
      S_SQ_B:   s_r <= sq_rnd[59:24];
      S_SIZE_B: begin
        if (which_r) begin
          pw_r <= sz_rnd[51:24];
        end else begin
          ph_r <= sz_rnd[51:24];
        end
      end
      S_CORNER: begin
        x0_r <= clamp_lim(cx_w - $signed({3'd0, hw}), xlim);
        x1_r <= clamp_lim(cx_w + $signed({3'd0, hw}), xlim);
        y0_r <= clamp_lim(cy_w - $signed({3'd0, hh}), ylim);
        y1_r <= clamp_lim(cy_w + $signed({3'd0, hh}), ylim);
      end
      S_INTER: begin
        iw_r <= (iw_d > 17'sd0) ? iw_d[15:0] : 16'd0;
        ih_r <= (ih_d > 17'sd0) ? ih_d[15:0] : 16'd0;
      end
      S_MUL_P:  inter_r <= prod_r[31:0];
      S_MUL_T:  parea_r <= prod_r[31:0];
      S_DONE: begin
        if (out_free) begin
          out_data_r.box_xmin      <= x0_r;
          out_data_r.box_ymin      <= y0_r;
          out_data_r.box_xmax      <= x1_r;
          out_data_r.box_ymax      <= y1_r;
          out_data_r.overlap_ratio <= div_rsp.quot;
          out_data_r.best_anchor   <= take ? count_r : best_idx_r;
          out_data_r.best_ratio    <= take ? div_rsp.quot : best_val_r;
          out_data_r.pass_done     <= item_r.last_anchor;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE)) else $error("result not from done");
  a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.best_ratio >= out_data_r.overlap_ratio))
    else $error("best ratio below current ratio");
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.box_xmin <= out_data_r.box_xmax &&
                     out_data_r.box_ymin <= out_data_r.box_ymax))
    else $error("box corners out of order");

endmodule

/* rtl/abdiou_div.sv */
// abdiou_div: radix-2 restoring divider for the iou quotient inter*65536/denom
// handles a non-positive denominator and saturation before the bit loop
// depends on abdiou_pkg
module abdiou_div (
  input  logic                clk,
  input  logic                rst_n,
  input  abdiou_pkg::div_req_t req,
  output abdiou_pkg::div_rsp_t rsp
);
  import abdiou_pkg::*;

  localparam logic [4:0] CNT_INIT = 5'(QUOT_W);

  logic [34:0]       rem_r;
  logic [34:0]       den_r;
  logic [QUOT_W-1:0] quot_r;
  logic [4:0]        cnt_r;
  logic              fix_r;
  logic              done_r;
  logic [35:0]       rem2;
  logic [35:0]       rem_sub;
  logic              no_den;
  logic              sat;

  // special cases at start
  assign no_den = req.denom[35] || (req.denom == 36'sd0);
  assign sat    = {4'd0, req.inter} >= req.denom[35:0];

  // one quotient bit per cycle
  assign rem2    = {rem_r, 1'b0};
  assign rem_sub = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      fix_r  <= 1'b0;
    end else begin
      done_r <= (cnt_r == 5'd1);
      if (req.start) begin
        cnt_r <= CNT_INIT;
        fix_r <= no_den || sat;
      end else if (cnt_r != 5'd0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.denom[34:0];
      rem_r <= {3'd0, req.inter};
      if (no_den) begin
        quot_r <= '0;
      end else if (sat) begin
        quot_r <= '1;
      end else begin
        quot_r <= '0;
      end
    end else if (cnt_r != 5'd0 && !fix_r) begin
      if (!rem_sub[35]) begin
        rem_r  <= rem_sub[34:0];
        quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem2[34:0];
        quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (cnt_r != 5'd0)) else $error("divider not busy after start");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 5'd0 && !fix_r) |-> (rem_r < den_r)) else $error("remainder out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == 5'd0)) else $error("done while still stepping");

endmodule

/* sim/tb.sv */
// tb: self-checking bench for anchor_box_decode_iou_argmax (box decode, iou, arg-max)
// predicts every result in fixed point and compares it field by field with the dut
// depends on abdiou_pkg and rtl/anchor_box_decode_iou_argmax.sv
module tb;
  import abdiou_pkg::*;

  // index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  anchor_box_decode_iou_argmax dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // register copies used by the box predictor
  longint img_w, img_h, gt_x0, gt_y0, gt_x1, gt_y1, eps_bias;
  // pass tracking copy
  longint pass_count, pass_best_idx, pass_best_val;
  bit pass_started;

  out_item_t box_queue[$];
  int err_count = 0;
  int sent_count;
  int result_count = 0;
  int pass_count_done = 0;
  int idle_pct;
  int stall_pct;
  // long hold-off: requests from the test side, counted down by the receiver
  int hold_left = 0;
  int hold_req = 0;
  int hold_ack = 0;

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // exp of a Q4.12 delta in Q.24: taylor series then four squarings
  function automatic longint unsigned exp_fix(longint d);
    longint one;
    longint x;
    longint term;
    longint total;
    longint unsigned s;
    one = 64'sd16777216;
    x = d * 256;
    term = one;
    total = one;
    for (longint n = 1; n <= 10; n++) begin
      term = (term * x) / one;
      term = term / n;
      total = total + term;
    end
    s = (total > 0) ? longint'(total) : 0;
    repeat (4) s = (s * s + 64'd8388608) >> 24;
    return s;
  endfunction

  function automatic longint clamp_lim(longint v, longint lim);
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic longint max2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint min2(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  // decode, clamp, iou and arg-max update for one anchor
  function automatic out_item_t predict_box(in_item_t it);
    out_item_t r;
    longint dx, dy, dh, dw, acx, acy, ah, aw;
    longint cx, cy, ph, pw, xlim, ylim, x0, y0, x1, y1;
    longint iw, ih, inter, denom, q, ratio;
    dx = longint'(signed'(it.delta_x));
    dy = longint'(signed'(it.delta_y));
    dh = longint'(signed'(it.delta_h));
    dw = longint'(signed'(it.delta_w));
    acx = longint'(it.anchor_cx);
    acy = longint'(it.anchor_cy);
    ah = longint'(it.anchor_h);
    aw = longint'(it.anchor_w);
    cx = acx + floor_div(aw * dx + 2048, 4096);
    cy = acy + floor_div(ah * dy + 2048, 4096);
    ph = longint'((unsigned'(ah) * exp_fix(dh) + 64'd8388608) >> 24);
    pw = longint'((unsigned'(aw) * exp_fix(dw) + 64'd8388608) >> 24);
    xlim = (img_w != 0) ? (img_w - 1) * 16 : 0;
    ylim = (img_h != 0) ? (img_h - 1) * 16 : 0;
    x0 = clamp_lim(cx - (pw >>> 1), xlim);
    y0 = clamp_lim(cy - (ph >>> 1), ylim);
    x1 = clamp_lim(cx + (pw >>> 1), xlim);
    y1 = clamp_lim(cy + (ph >>> 1), ylim);
    iw = max2(0, min2(x1, gt_x1) - max2(x0, gt_x0));
    ih = max2(0, min2(y1, gt_y1) - max2(y0, gt_y0));
    inter = iw * ih;
    denom = (x1 - x0) * (y1 - y0) + (gt_x1 - gt_x0) * (gt_y1 - gt_y0) - inter + eps_bias;
    ratio = 0;
    if (denom > 0) begin
      q = (inter * 65536) / denom;
      ratio = (q > 65535) ? 65535 : q;
    end
    // strictly higher iou replaces the best
    if (!pass_started || ratio > pass_best_val) begin
      pass_best_val = ratio;
      pass_best_idx = pass_count;
      pass_started = 1'b1;
    end
    r.box_xmin = x0[15:0];
    r.box_ymin = y0[15:0];
    r.box_xmax = x1[15:0];
    r.box_ymax = y1[15:0];
    r.overlap_ratio = ratio[15:0];
    r.best_anchor = pass_best_idx[13:0];
    r.best_ratio = pass_best_val[15:0];
    r.pass_done = it.last_anchor;
    if (it.last_anchor) begin
      pass_count = 0;
      pass_best_idx = 0;
      pass_best_val = 0;
      pass_started = 1'b0;
    end else begin
      pass_count = (pass_count + 1 >= MAX_ANCHORS_DEF) ? 0 : pass_count + 1;
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // result side: random stall or long hold-off, compare each transfer
  always @(posedge clk) begin
    out_item_t want;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_ack <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (box_queue.size() == 0) begin
        $error("result with no expected item waiting");
        err_count++;
      end else begin
        want = box_queue.pop_front();
        check_field("box_xmin", want.box_xmin, out_data.box_xmin);
        check_field("box_ymin", want.box_ymin, out_data.box_ymin);
        check_field("box_xmax", want.box_xmax, out_data.box_xmax);
        check_field("box_ymax", want.box_ymax, out_data.box_ymax);
        check_field("overlap_ratio", want.overlap_ratio, out_data.overlap_ratio);
        check_field("best_anchor", want.best_anchor, out_data.best_anchor);
        check_field("best_ratio", want.best_ratio, out_data.best_ratio);
        check_field("pass_done", want.pass_done, out_data.pass_done);
        if (want.pass_done) pass_count_done++;
      end
    end
  end

  // offer one anchor, idling first at random; valid stays high afterwards
  task automatic send_anchor(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    box_queue.insert(box_queue.size(), predict_box(it));
    sent_count++;
    do @(posedge clk); while (in_stall);
  endtask

  // lower valid and wait until every result has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (box_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val & 12'hFFF;
      CFG_IMAGE_HEIGHT: img_h = val & 12'hFFF;
      CFG_TRUTH_XMIN:   gt_x0 = val & 16'hFFFF;
      CFG_TRUTH_YMIN:   gt_y0 = val & 16'hFFFF;
      CFG_TRUTH_XMAX:   gt_x1 = val & 16'hFFFF;
      CFG_TRUTH_YMAX:   gt_y1 = val & 16'hFFFF;
      CFG_UNION_BIAS:   eps_bias = val & 8'hFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // full register set, plus a write to the unused index
  task automatic set_scene(longint w, longint h, longint x0, longint y0, longint x1,
                           longint y1, longint bias);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_TRUTH_XMIN, x0);
    cfg_write(CFG_TRUTH_YMIN, y0);
    cfg_write(CFG_TRUTH_XMAX, x1);
    cfg_write(CFG_TRUTH_YMAX, y1);
    cfg_write(CFG_UNION_BIAS, bias);
    cfg_write(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_anchor(int dx, int dy, int dh, int dw, int cx, int cy,
                                           int h, int w, bit last);
    in_item_t it;
    it.delta_x = dx[15:0];
    it.delta_y = dy[15:0];
    it.delta_h = dh[15:0];
    it.delta_w = dw[15:0];
    it.anchor_cx = cx[15:0];
    it.anchor_cy = cy[15:0];
    it.anchor_h = h[15:0];
    it.anchor_w = w[15:0];
    it.last_anchor = last;
    return it;
  endfunction

  // mostly anchors near the truth box with modest deltas, some raw noise
  function automatic in_item_t random_anchor();
    in_item_t it;
    int gcx, gcy, gh, gw;
    logic [159:0] raw;
    if ($urandom_range(99) < 80) begin
      gcx = int'((gt_x0 + gt_x1) / 2);
      gcy = int'((gt_y0 + gt_y1) / 2);
      gw = int'(max2(gt_x1 - gt_x0, 16));
      gh = int'(max2(gt_y1 - gt_y0, 16));
      it = make_anchor($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
                       $urandom_range(3000) - 1500, $urandom_range(3000) - 1500,
                       gcx + $urandom_range(gw) - gw / 2, gcy + $urandom_range(gh) - gh / 2,
                       gh / 2 + $urandom_range(gh), gw / 2 + $urandom_range(gw), 1'b0);
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    end
    it.last_anchor = ($urandom_range(15) == 0);
    return it;
  endfunction

  // a few anchors under the reset register values
  task automatic test_reset_scene;
    send_anchor(make_anchor(0, 0, 0, 0, 3200, 3200, 640, 640, 1'b0));
    send_anchor(make_anchor(100, -100, 200, -200, 0, 0, 160, 160, 1'b1));
    drain();
  endtask

  // extremes, clamping, ties, a saturated iou of one, zero denominator, zero image size
  task automatic test_directed;
    set_scene(4095, 4095, 1600, 1600, 4800, 4800, 0);
    send_anchor(make_anchor(0, 0, 0, 0, 3200, 3200, 3200, 3200, 1'b0));
    send_anchor(make_anchor(0, 0, 0, 0, 3200, 3200, 3200, 3200, 1'b0));
    send_anchor(make_anchor(32767, 32767, 32767, 32767, 65535, 65535, 65535, 65535, 1'b0));
    send_anchor(make_anchor(-32768, -32768, -32768, -32768, 0, 0, 65535, 65535, 1'b0));
    send_anchor(make_anchor(-32768, 32767, 32767, -32768, 0, 65535, 0, 0, 1'b0));
    send_anchor(make_anchor(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_anchor(make_anchor(4096, -4096, 8192, -8192, 100, 65000, 8000, 8000, 1'b1));
    drain();
    // misordered truth box: both extents negative, so the truth area stays positive and no box overlaps
    set_scene(416, 416, 4000, 4000, 1000, 1000, 255);
    send_anchor(make_anchor(0, 0, 0, 0, 2500, 2500, 2000, 2000, 1'b0));
    send_anchor(make_anchor(0, 0, 0, 0, 3000, 3000, 600, 600, 1'b0));
    send_anchor(make_anchor(0, 0, -32768, -32768, 2500, 2500, 1, 1, 1'b1));
    drain();
    // zero image size collapses every box and the denominator
    set_scene(0, 0, 0, 0, 0, 0, 0);
    send_anchor(make_anchor(0, 0, 0, 0, 100, 100, 50, 50, 1'b0));
    send_anchor(make_anchor(1000, 1000, 1000, 1000, 65535, 65535, 65535, 65535, 1'b1));
    drain();
    set_scene(1, 4095, 65535, 0, 65535, 65535, 1);
    send_anchor(make_anchor(0, 0, 0, 0, 0, 30000, 100, 100, 1'b0));
    send_anchor(make_anchor(0, 0, 4096, 4096, 65535, 65535, 65535, 65535, 1'b1));
    drain();
  endtask

  task automatic random_scene;
    longint w, h, x0, y0;
    w = $urandom_range(4095, 16);
    h = $urandom_range(4095, 16);
    x0 = $urandom_range(int'((w - 1) * 16));
    y0 = $urandom_range(int'((h - 1) * 16));
    set_scene(w, h, x0, y0, x0 + $urandom_range(int'(min2(w * 16 - x0, 4000))),
              y0 + $urandom_range(int'(min2(h * 16 - y0, 4000))), $urandom_range(255));
  endtask

  // random anchors under one idle and stall pattern
  task automatic test_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    random_scene();
    repeat (n) send_anchor(random_anchor());
    drain();
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_hold_off;
    idle_pct = 0;
    stall_pct = 0;
    random_scene();
    hold_req++;
    repeat (12) send_anchor(random_anchor());
    drain();
  endtask

  // sender waits for every result between short bursts
  task automatic test_pause;
    idle_pct = 20;
    stall_pct = 30;
    random_scene();
    repeat (4) begin
      repeat (5) send_anchor(random_anchor());
      in_valid <= 1'b0;
      @(posedge clk);
      while (box_queue.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    img_w = 416;
    img_h = 416;
    gt_x0 = 0;
    gt_y0 = 0;
    gt_x1 = 0;
    gt_y1 = 0;
    eps_bias = 1;
    pass_count = 0;
    pass_best_idx = 0;
    pass_best_val = 0;
    pass_started = 1'b0;
    sent_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_scene();
    test_directed();
    test_random(500, 0, 0);
    test_random(450, 72, 0);
    test_random(450, 0, 72);
    test_random(500, 7, 7);
    test_hold_off();
    test_pause();

    $display("covered %0d anchors, %0d results, %0d closed passes", sent_count,
             result_count, pass_count_done);
    $display("register scenes included zero and full image sizes and a misordered truth box");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // timeout
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
